// ===== hdl/cme_pkg.sv =====
// Shared constants, the front-to-back command type and helper functions
// for the complementary MSD engine. No dependencies.
`timescale 1ns / 1ps
package cme_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ELEM_W   = 16;

	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int CNT_W    = ROW_W + 1;
	localparam int CCNT_W   = COL_W + 1;
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;

	localparam int ATOM_W   = 16;
	localparam int COLCFG_W = 7;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	localparam int S1_W     = ELEM_W + ROW_W;
	localparam int XX_W     = 2 * ELEM_W;
	localparam int SQ_W     = XX_W + ROW_W;
	localparam int B_W      = S1_W + 1;
	localparam int A_W      = SQ_W + 1;
	localparam int P_W      = (A_W + ROW_W + 1 > 2 * B_W) ? (A_W + ROW_W + 1) : (2 * B_W);
	localparam int TOT_W    = P_W + 2 + COL_W;
	localparam int DIVD_W   = TOT_W - 1;
	localparam int DCNT_W   = $clog2(DIVD_W);
	localparam int DEN_W    = 2 * ROW_W + ATOM_W;
	localparam int REM_W    = DEN_W + 1;
	localparam int OUT_W    = 48;
	localparam int ST_W     = 2;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);

	localparam logic [ST_W-1:0] ST_OK  = 2'd0;
	localparam logic [ST_W-1:0] ST_ERR = 2'd1;
	localparam logic [ST_W-1:0] ST_SAT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ATOMS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 1'b1;

	typedef struct packed {
		logic signed [ELEM_W-1:0] x;
		logic [COL_W-1:0]         col;
		logic [ROW_W-1:0]         row;
		logic                     store;
		logic                     last;
		logic                     err;
		logic [CNT_W-1:0]         nrows;
	} cmd_t;

	function automatic logic [CCNT_W-1:0] clamp_cols(input logic [COLCFG_W-1:0] v);
		logic [CCNT_W-1:0] r;
		if (v == '0) begin
			r = CCNT_W'(1);
		end else if (int'(v) > MAX_COLS) begin
			r = CCNT_W'(MAX_COLS);
		end else begin
			r = CCNT_W'(v);
		end
		return r;
	endfunction

	function automatic logic [ATOM_W-1:0] clamp_atoms(input logic [ATOM_W-1:0] v);
		return (v == '0) ? ATOM_W'(1) : v;
	endfunction

endpackage

// ===== hdl/cme_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
// Depends on cme_pkg.
`timescale 1ns / 1ps
interface cme_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [cme_pkg::ELEM_W-1:0] element_value;
	logic                             end_of_matrix;
	modport source (output valid, element_value, end_of_matrix, input ready);
	modport sink   (input valid, element_value, end_of_matrix, output ready);
endinterface

interface cme_out_if;
	logic                        valid;
	logic                        ready;
	logic [cme_pkg::ROW_W-1:0]   row_index;
	logic [cme_pkg::OUT_W-1:0]   deviation_value;
	logic [cme_pkg::ST_W-1:0]    status;
	logic                        last_result;
	modport source (output valid, row_index, deviation_value, status, last_result, input ready);
	modport sink   (input valid, row_index, deviation_value, status, last_result, output ready);
endinterface

// ===== hdl/complementary_msd_engine_top.sv =====
// Top level of the complementary MSD engine: configuration registers and the
// front end, command queue and back end. Depends on cme_pkg, cme_if, cme_front,
// cme_queue, cme_back.
// Load: the back end pops each element, then reads and writes the column sum
// RAMs; the front end takes one item per cycle until the 4-entry queue fills.
// Report: one result per row once the end item is loaded; the 53-step restoring
// divider and the column walk (B_RD, B_C1 to B_C4) set the report time.
// Reset clears counters, queue, output valid bit and column valid bits; the
// element store is not cleared and no clearing pass runs.
`timescale 1ns / 1ps
module complementary_msd_engine_top (
	input  logic                            clk,
	input  logic                            arst_n,
	cme_in_if.sink                          in_ch,
	cme_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [cme_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cme_pkg::CFG_W-1:0]       cfg_data
);
	logic [cme_pkg::ATOM_W-1:0]   atom_count_q;
	logic [cme_pkg::COLCFG_W-1:0] column_count_q;
	logic                         push;
	cme_pkg::cmd_t                push_cmd;
	logic                         q_full;
	logic                         q_valid;
	cme_pkg::cmd_t                q_head;
	logic                         pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_count_q   <= cme_pkg::ATOM_W'(1);
			column_count_q <= cme_pkg::COLCFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				cme_pkg::CFG_ATOMS: atom_count_q   <= cfg_data[cme_pkg::ATOM_W-1:0];
				cme_pkg::CFG_COLS:  column_count_q <= cfg_data[cme_pkg::COLCFG_W-1:0];
				default: ;
			endcase
		end
	end

	cme_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .column_count(column_count_q),
		.q_full(q_full), .push(push), .push_cmd(push_cmd)
	);

	cme_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(push_cmd), .pop(pop),
		.full(q_full), .not_empty(q_valid), .head(q_head)
	);

	cme_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_head), .pop(pop),
		.column_count(column_count_q), .atom_count(atom_count_q), .out_ch(out_ch)
	);
endmodule

// ===== hdl/cme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/cme_front.sv =====
// Front end: accepts items, tracks row and column position, and turns each
// item into a command for the back end. Depends on cme_pkg, cme_if.
`timescale 1ns / 1ps
module cme_front (
	input  logic                            clk,
	input  logic                            arst_n,
	cme_in_if.sink                          in_ch,
	input  logic [cme_pkg::COLCFG_W-1:0]    column_count,
	input  logic                            q_full,
	output logic                            push,
	output cme_pkg::cmd_t                   push_cmd
);
	logic [cme_pkg::CNT_W-1:0]  row_q;
	logic [cme_pkg::CCNT_W-1:0] colpos_q;
	logic [cme_pkg::CCNT_W-1:0] cols;
	logic [cme_pkg::CCNT_W-1:0] c_sel;
	logic [cme_pkg::CCNT_W-1:0] colpos_n;
	logic [cme_pkg::CNT_W-1:0]  row_n;
	logic                       store;

	assign cols        = cme_pkg::clamp_cols(column_count);
	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;
	assign store       = int'(row_q) < cme_pkg::MAX_ROWS;
	assign c_sel       = (colpos_q >= cols) ? cols - 1'b1 : colpos_q;

	always_comb begin
		row_n    = row_q;
		colpos_n = colpos_q;
		if (store) begin
			if (c_sel + 1'b1 >= cols) begin
				colpos_n = '0;
				row_n    = row_q + 1'b1;
			end else begin
				colpos_n = c_sel + 1'b1;
			end
		end
	end

	always_comb begin
		push_cmd.x     = in_ch.element_value;
		push_cmd.col   = c_sel[cme_pkg::COL_W-1:0];
		push_cmd.row   = row_q[cme_pkg::ROW_W-1:0];
		push_cmd.store = store;
		push_cmd.last  = in_ch.end_of_matrix;
		push_cmd.err   = (row_n < cme_pkg::CNT_W'(2)) || (colpos_n != '0);
		push_cmd.nrows = row_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			colpos_q <= '0;
		end else if (push) begin
			if (in_ch.end_of_matrix) begin
				row_q    <= '0;
				colpos_q <= '0;
			end else begin
				row_q    <= row_n;
				colpos_q <= colpos_n;
			end
		end
	end
endmodule

// ===== hdl/cme_queue.sv =====
// Short command queue between front and back end.
// Depends on cme_pkg.
`timescale 1ns / 1ps
module cme_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cme_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output cme_pkg::cmd_t head
);
	cme_pkg::cmd_t                 buf_q [cme_pkg::QDEPTH];
	logic [cme_pkg::QPTR_W-1:0]    wptr_q;
	logic [cme_pkg::QPTR_W-1:0]    rptr_q;
	logic [cme_pkg::QPTR_W:0]      cnt_q;

	assign full      = (int'(cnt_q) == cme_pkg::QDEPTH);
	assign not_empty = (cnt_q != '0);
	assign head      = buf_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== hdl/cme_back.sv =====
// Back end: accumulates column sums into RAM, then walks rows and columns,
// divides and emits results. Depends on cme_pkg, cme_if, cme_ram.
`timescale 1ns / 1ps
module cme_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  cme_pkg::cmd_t                 q_cmd,
	output logic                          pop,
	input  logic [cme_pkg::COLCFG_W-1:0]  column_count,
	input  logic [cme_pkg::ATOM_W-1:0]    atom_count,
	cme_out_if.source                     out_ch
);
	typedef enum logic [13:0] {
		B_IDLE  = 14'b00000000000001,
		B_LD_RD = 14'b00000000000010,
		B_LD_WR = 14'b00000000000100,
		B_ERR   = 14'b00000000001000,
		B_PREP  = 14'b00000000010000,
		B_PREP2 = 14'b00000000100000,
		B_RD    = 14'b00000001000000,
		B_C1    = 14'b00000010000000,
		B_C2    = 14'b00000100000000,
		B_C3    = 14'b00001000000000,
		B_C4    = 14'b00010000000000,
		B_DINIT = 14'b00100000000000,
		B_DIV   = 14'b01000000000000,
		B_EMIT  = 14'b10000000000000
	} bstate_t;

	bstate_t                             st_q;
	cme_pkg::cmd_t                       cmd_q;
	logic [cme_pkg::MAX_COLS-1:0]        valid_q;
	logic                                vld_r_q;
	logic [cme_pkg::ROW_W-1:0]           row_q;
	logic [cme_pkg::COL_W-1:0]           col_q;
	logic [cme_pkg::ROW_W-1:0]           nm1_q;
	logic [2*cme_pkg::ROW_W-1:0]         nm1sq_q;
	logic [cme_pkg::DEN_W-1:0]           denom_q;
	logic signed [cme_pkg::XX_W-1:0]     xx_q;
	logic signed [cme_pkg::B_W-1:0]      b_q;
	logic signed [cme_pkg::SQ_W-1:0]     s2_q;
	logic signed [cme_pkg::A_W-1:0]      a_q;
	logic signed [cme_pkg::P_W-1:0]      p1_q;
	logic signed [cme_pkg::P_W-1:0]      p2_q;
	logic signed [cme_pkg::TOT_W-1:0]    total_q;
	logic [cme_pkg::DIVD_W-1:0]          divd_q;
	logic [cme_pkg::REM_W-1:0]           rem_q;
	logic [cme_pkg::DCNT_W-1:0]          dcnt_q;

	logic                                ov_q;
	logic [cme_pkg::ROW_W-1:0]           orow_q;
	logic [cme_pkg::OUT_W-1:0]           odev_q;
	logic [cme_pkg::ST_W-1:0]            ost_q;
	logic                                olast_q;

	logic                                out_free;
	logic                                emit_now;
	logic [cme_pkg::CCNT_W-1:0]          cols;
	logic                                elem_we;
	logic [cme_pkg::ADDR_W-1:0]          elem_waddr;
	logic [cme_pkg::ADDR_W-1:0]          elem_raddr;
	logic signed [cme_pkg::ELEM_W-1:0]   elem_rdata;
	logic                                acc_we;
	logic [cme_pkg::COL_W-1:0]           acc_raddr;
	logic signed [cme_pkg::S1_W-1:0]     sum_rdata;
	logic signed [cme_pkg::SQ_W-1:0]     sq_rdata;
	logic signed [cme_pkg::S1_W-1:0]     sum_old;
	logic signed [cme_pkg::SQ_W-1:0]     sq_old;
	logic signed [cme_pkg::S1_W-1:0]     sum_wdata;
	logic signed [cme_pkg::SQ_W-1:0]     sq_wdata;
	logic signed [cme_pkg::ELEM_W-1:0]   x_mul;
	logic [cme_pkg::ROW_W-1:0]           nm1_w;
	logic [cme_pkg::REM_W-1:0]           rem_sh;
	logic                                ge;
	logic                                sat;
	logic                                last_row;
	logic                                last_col;

	assign out_free   = !ov_q || out_ch.ready;
	assign emit_now   = out_free && ((st_q == B_ERR) || (st_q == B_EMIT));
	assign cols       = cme_pkg::clamp_cols(column_count);
	assign pop        = (st_q == B_IDLE) && q_valid;

	assign elem_we    = (st_q == B_LD_RD) && cmd_q.store;
	assign elem_waddr = {cmd_q.row, cmd_q.col};
	assign elem_raddr = {row_q, col_q};
	assign acc_we     = (st_q == B_LD_WR);
	assign acc_raddr  = (st_q == B_LD_RD) ? cmd_q.col : col_q;

	assign sum_old    = vld_r_q ? sum_rdata : '0;
	assign sq_old     = vld_r_q ? sq_rdata : '0;
	assign sum_wdata  = sum_old + cme_pkg::S1_W'(cmd_q.x);
	assign sq_wdata   = sq_old + cme_pkg::SQ_W'(xx_q);
	assign x_mul      = (st_q == B_C1) ? elem_rdata : cmd_q.x;
	assign nm1_w      = cme_pkg::ROW_W'(cmd_q.nrows - 1'b1);

	assign rem_sh     = {rem_q[cme_pkg::REM_W-2:0], divd_q[cme_pkg::DIVD_W-1]};
	assign ge         = rem_sh >= {1'b0, denom_q};
	assign sat        = |divd_q[cme_pkg::DIVD_W-1:cme_pkg::OUT_W];
	assign last_row   = ({1'b0, row_q} == cme_pkg::CNT_W'(cmd_q.nrows - 1'b1));
	assign last_col   = ({1'b0, col_q} == cols - 1'b1);

	cme_ram #(.WIDTH(cme_pkg::ELEM_W), .DEPTH(cme_pkg::DEPTH)) u_elem (
		.clk(clk), .we(elem_we), .waddr(elem_waddr), .wdata(cmd_q.x),
		.raddr(elem_raddr), .rdata(elem_rdata)
	);
	cme_ram #(.WIDTH(cme_pkg::S1_W), .DEPTH(cme_pkg::MAX_COLS)) u_sum (
		.clk(clk), .we(acc_we), .waddr(cmd_q.col), .wdata(sum_wdata),
		.raddr(acc_raddr), .rdata(sum_rdata)
	);
	cme_ram #(.WIDTH(cme_pkg::SQ_W), .DEPTH(cme_pkg::MAX_COLS)) u_sq (
		.clk(clk), .we(acc_we), .waddr(cmd_q.col), .wdata(sq_wdata),
		.raddr(acc_raddr), .rdata(sq_rdata)
	);

	assign out_ch.valid           = ov_q;
	assign out_ch.row_index       = orow_q;
	assign out_ch.deviation_value = odev_q;
	assign out_ch.status          = ost_q;
	assign out_ch.last_result     = olast_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= B_IDLE;
			valid_q <= '0;
			ov_q    <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
			dcnt_q  <= '0;
		end else begin
			if (emit_now) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				B_IDLE: begin
					if (q_valid) begin
						if (q_cmd.store) begin
							st_q <= B_LD_RD;
						end else if (q_cmd.last) begin
							st_q <= q_cmd.err ? B_ERR : B_PREP;
						end
					end
				end
				B_LD_RD: st_q <= B_LD_WR;
				B_LD_WR: begin
					valid_q[cmd_q.col] <= 1'b1;
					if (cmd_q.last) begin
						st_q <= cmd_q.err ? B_ERR : B_PREP;
					end else begin
						st_q <= B_IDLE;
					end
				end
				B_ERR: begin
					if (out_free) begin
						valid_q <= '0;
						st_q    <= B_IDLE;
					end
				end
				B_PREP: begin
					row_q <= '0;
					col_q <= '0;
					st_q  <= B_PREP2;
				end
				B_PREP2: st_q <= B_RD;
				B_RD:    st_q <= B_C1;
				B_C1:    st_q <= B_C2;
				B_C2:    st_q <= B_C3;
				B_C3:    st_q <= B_C4;
				B_C4: begin
					if (last_col) begin
						st_q <= B_DINIT;
					end else begin
						col_q <= col_q + 1'b1;
						st_q  <= B_RD;
					end
				end
				B_DINIT: begin
					dcnt_q <= '0;
					st_q   <= B_DIV;
				end
				B_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (int'(dcnt_q) == cme_pkg::DIVD_W - 1) begin
						st_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (out_free) begin
						if (last_row) begin
							valid_q <= '0;
							st_q    <= B_IDLE;
						end else begin
							row_q <= row_q + 1'b1;
							col_q <= '0;
							st_q  <= B_RD;
						end
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		vld_r_q <= valid_q[acc_raddr];
		xx_q    <= x_mul * x_mul;
		if (pop) begin
			cmd_q <= q_cmd;
		end
		case (st_q)
			B_ERR: begin
				if (out_free) begin
					orow_q  <= '0;
					odev_q  <= '0;
					ost_q   <= cme_pkg::ST_ERR;
					olast_q <= 1'b1;
				end
			end
			B_PREP: begin
				nm1_q   <= nm1_w;
				nm1sq_q <= nm1_w * nm1_w;
				total_q <= '0;
			end
			B_PREP2: denom_q <= cme_pkg::DEN_W'(nm1sq_q * cme_pkg::clamp_atoms(atom_count));
			B_C1: begin
				b_q  <= cme_pkg::B_W'(sum_old) - cme_pkg::B_W'(elem_rdata);
				s2_q <= sq_old;
			end
			B_C2: a_q <= cme_pkg::A_W'(s2_q) - cme_pkg::A_W'(xx_q);
			B_C3: begin
				p1_q <= cme_pkg::P_W'(signed'({1'b0, nm1_q})) * cme_pkg::P_W'(a_q);
				p2_q <= cme_pkg::P_W'(b_q) * cme_pkg::P_W'(b_q);
			end
			B_C4: total_q <= total_q + (cme_pkg::TOT_W'(p1_q - p2_q) <<< 1);
			B_DINIT: begin
				divd_q <= total_q[cme_pkg::TOT_W-1] ? '0 : total_q[cme_pkg::DIVD_W-1:0];
				rem_q  <= '0;
			end
			B_DIV: begin
				rem_q  <= ge ? rem_sh - {1'b0, denom_q} : rem_sh;
				divd_q <= {divd_q[cme_pkg::DIVD_W-2:0], ge};
			end
			B_EMIT: begin
				if (out_free) begin
					orow_q  <= row_q;
					odev_q  <= sat ? '1 : divd_q[cme_pkg::OUT_W-1:0];
					ost_q   <= sat ? cme_pkg::ST_SAT : cme_pkg::ST_OK;
					olast_q <= last_row;
					total_q <= '0;
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== hdl/cme_checker.sv =====
// Port-level checks on the result channel of the engine, bound to the top.
// Depends on cme_pkg, complementary_msd_engine_top.
`timescale 1ns / 1ps
module cme_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [cme_pkg::ROW_W-1:0]   row_index,
	input logic [cme_pkg::OUT_W-1:0]   deviation_value,
	input logic [cme_pkg::ST_W-1:0]    status,
	input logic                        last_result
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(deviation_value) && $stable(row_index))
		else $error("result changed while stalled");

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cme_pkg::ST_ERR |->
			last_result && row_index == '0 && deviation_value == '0)
		else $error("malformed error result");

	a_sat_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cme_pkg::ST_SAT |-> &deviation_value)
		else $error("saturated result not at full scale");

	a_row_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_result ##1 out_valid |->
			row_index == $past(row_index) + 1'b1)
		else $error("row index out of sequence");
endmodule

bind complementary_msd_engine_top cme_checker u_cme_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.row_index(out_ch.row_index), .deviation_value(out_ch.deviation_value),
	.status(out_ch.status), .last_result(out_ch.last_result)
);

// ===== tb/sv/cme_msd_checker.sv =====
// Checker for the complementary MSD engine: watches the element, result and
// register-write ports, predicts each row deviation and compares in order.
// Depends on cme_pkg and cme_if.
`timescale 1ns / 1ps
module cme_msd_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	cme_in_if                               in_ch,
	cme_out_if                              out_ch,
	input  logic                            cfg_we,
	input  logic [cme_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cme_pkg::CFG_W-1:0]       cfg_data,
	output int                              fail_count,
	output int                              pending
);
	typedef struct {
		logic [cme_pkg::ROW_W-1:0] row;
		logic [cme_pkg::OUT_W-1:0] dev;
		logic [cme_pkg::ST_W-1:0]  st;
		logic                      last;
	} dev_result_t;

	localparam longint unsigned DEV_SAT = (64'd1 << cme_pkg::OUT_W) - 64'd1;

	dev_result_t dev_queue[$];
	logic [cme_pkg::ATOM_W-1:0]   atoms_reg;
	logic [cme_pkg::COLCFG_W-1:0] cols_reg;
	longint mat_store[cme_pkg::MAX_ROWS*cme_pkg::MAX_COLS];
	longint col_sum[cme_pkg::MAX_COLS];
	longint col_sq_sum[cme_pkg::MAX_COLS];
	int rows_done;
	int col_pos;

	function automatic void clear_matrix();
		for (int c = 0; c < cme_pkg::MAX_COLS; c++) begin
			col_sum[c] = 0;
			col_sq_sum[c] = 0;
		end
		rows_done = 0;
		col_pos = 0;
	endfunction

	function automatic void predict_element(logic signed [cme_pkg::ELEM_W-1:0] elem, logic eom);
		int ncols;
		int c;
		longint x;
		longint nm1;
		longint total;
		longint a;
		longint b;
		longint unsigned denom;
		longint unsigned q;
		dev_result_t r;
		ncols = (cols_reg == 0) ? 1 :
			(int'(cols_reg) > cme_pkg::MAX_COLS ? cme_pkg::MAX_COLS : int'(cols_reg));
		if (rows_done < cme_pkg::MAX_ROWS) begin
			x = longint'(elem);
			c = (col_pos >= ncols) ? ncols - 1 : col_pos;
			mat_store[rows_done*cme_pkg::MAX_COLS + c] = x;
			col_sum[c] += x;
			col_sq_sum[c] += x * x;
			col_pos = c + 1;
			if (col_pos >= ncols) begin
				col_pos = 0;
				rows_done++;
			end
		end
		if (!eom) return;
		if (rows_done < 2 || col_pos != 0) begin
			r.row = '0;
			r.dev = '0;
			r.st = cme_pkg::ST_ERR;
			r.last = 1'b1;
			dev_queue.push_back(r);
		end else begin
			nm1 = rows_done - 1;
			denom = longint'(nm1 * nm1) * ((atoms_reg == 0) ? 64'd1 : 64'(atoms_reg));
			for (int i = 0; i < rows_done; i++) begin
				total = 0;
				for (int k = 0; k < ncols; k++) begin
					x = mat_store[i*cme_pkg::MAX_COLS + k];
					a = col_sq_sum[k] - x * x;
					b = col_sum[k] - x;
					total += 2 * (nm1 * a - b * b);
				end
				if (total < 0) total = 0;
				q = longint'(total) / denom;
				r.st = cme_pkg::ST_OK;
				if (q > DEV_SAT) begin
					q = DEV_SAT;
					r.st = cme_pkg::ST_SAT;
				end
				r.row = cme_pkg::ROW_W'(i);
				r.dev = q[cme_pkg::OUT_W-1:0];
				r.last = (i + 1 == rows_done);
				dev_queue.push_back(r);
			end
		end
		clear_matrix();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dev_result_t e;
		if (!arst_n) begin
			atoms_reg = 1;
			cols_reg = 1;
			fail_count = 0;
			dev_queue.delete();
			clear_matrix();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (dev_queue.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result row %0d dev %0d status %0d last %0b",
						$time, out_ch.row_index, out_ch.deviation_value, out_ch.status,
						out_ch.last_result);
				end else begin
					e = dev_queue.pop_front();
					if (e.row !== out_ch.row_index || e.dev !== out_ch.deviation_value ||
					    e.st !== out_ch.status || e.last !== out_ch.last_result) begin
						fail_count++;
						$display({"%0t: mismatch exp row %0d dev %0d st %0d last %0b,",
							" got row %0d dev %0d st %0d last %0b"},
							$time, e.row, e.dev, e.st, e.last, out_ch.row_index,
							out_ch.deviation_value, out_ch.status, out_ch.last_result);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				predict_element(in_ch.element_value, in_ch.end_of_matrix);
			if (cfg_we) begin
				if (cfg_index == cme_pkg::CFG_ATOMS) atoms_reg = cfg_data[cme_pkg::ATOM_W-1:0];
				else if (cfg_index == cme_pkg::CFG_COLS)
					cols_reg = cfg_data[cme_pkg::COLCFG_W-1:0];
			end
		end
		pending = dev_queue.size();
	end
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the complementary MSD engine: clock, reset, matrix
// stimulus, register writes, result back-pressure and the verdict.
// Depends on cme_pkg, cme_if, complementary_msd_engine_top and cme_msd_checker.
`timescale 1ns / 1ps
module tb_top;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [cme_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [cme_pkg::CFG_W-1:0] cfg_data;
	int fail_count;
	int pending;
	int items_sent;
	bit quiet;
	bit long_hold;

	cme_in_if  in_ch();
	cme_out_if out_ch();

	complementary_msd_engine_top u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	cme_msd_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				for (int n = 0; n < 1500; n++) @(posedge clk);
				long_hold = 0;
			end else begin
				out_ch.ready <= quiet || ($urandom_range(0, 2) != 0);
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	function automatic logic [cme_pkg::ELEM_W-1:0] pick_element();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return cme_pkg::ELEM_W'($urandom_range(0, 31)) - 16'd16;
			default: return cme_pkg::ELEM_W'($urandom);
		endcase
	endfunction

	task automatic send_element(logic [cme_pkg::ELEM_W-1:0] v, logic eom);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.element_value <= v;
		in_ch.end_of_matrix <= eom;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	task automatic send_matrix(int rows, int ncols, int extra);
		int total;
		total = rows * ncols + extra;
		for (int k = 0; k < total; k++)
			send_element(pick_element(), k == total - 1);
	endtask

	task automatic wait_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_regs(logic [cme_pkg::ATOM_W-1:0] atoms,
			logic [cme_pkg::COLCFG_W-1:0] ncols);
		cfg_we <= 1'b1;
		cfg_index <= cme_pkg::CFG_ATOMS;
		cfg_data <= cme_pkg::CFG_W'(atoms);
		@(posedge clk);
		cfg_index <= cme_pkg::CFG_COLS;
		cfg_data <= cme_pkg::CFG_W'(ncols);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int ncols;
		int rows;
		int mat;
		logic [cme_pkg::ATOM_W-1:0] atoms;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= cme_pkg::CFG_ATOMS;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.element_value <= '0;
		in_ch.end_of_matrix <= 1'b0;
		items_sent = 0;
		quiet = 0;
		long_hold = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element: too few rows
		send_element(16'h7FFF, 1'b1);
		wait_results();
		// partial last row
		write_regs(16'd1, 7'd3);
		send_matrix(2, 3, 1);
		wait_results();
		// extremes with atom count zero
		write_regs(16'd0, 7'd2);
		send_element(16'h7FFF, 1'b0);
		send_element(16'h8000, 1'b0);
		send_element(16'h8000, 1'b0);
		send_element(16'h7FFF, 1'b0);
		send_element(16'h0000, 1'b0);
		send_element(16'hFFFF, 1'b1);
		wait_results();
		// column count zero behaves as one
		write_regs(16'd65535, 7'd0);
		send_matrix(3, 1, 0);
		wait_results();
		// column count above maximum, then more rows than the store holds
		write_regs(16'd7, 7'd127);
		send_matrix(3, cme_pkg::MAX_COLS, 0);
		wait_results();
		write_regs(16'd1, 7'd1);
		send_matrix(cme_pkg::MAX_ROWS + 2, 1, 0);
		wait_results();

		ncols = 1;
		mat = 0;
		while (items_sent < 430) begin
			if (items_sent > 370) quiet = 1;
			if (mat != 4 && mat != 5 && $urandom_range(0, 2) == 0) begin
				wait_results();
				case ($urandom_range(0, 3))
					0: atoms = 16'd1;
					1: atoms = 16'd65535;
					default: atoms = cme_pkg::ATOM_W'($urandom);
				endcase
				ncols = $urandom_range(1, 8);
				write_regs(atoms, cme_pkg::COLCFG_W'(ncols));
			end
			if (mat == 4) long_hold = 1;
			rows = $urandom_range(2, 7);
			case ($urandom_range(0, 9))
				0: send_matrix(1, ncols, 0);
				1: send_matrix(rows, ncols, (ncols > 1) ? $urandom_range(1, ncols - 1) : 0);
				default: send_matrix(rows, ncols, 0);
			endcase
			mat++;
		end
		wait_results();
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
